FILE: rtl/fera_pkg.sv
package fera_pkg;

   localparam int MAX_EXTENTS_DEFAULT = 16;
   localparam int ADDR_WIDTH_DEFAULT  = 16;
   localparam int MEMORY_SIZE_RESET   = 4096;
   localparam int FIELD_WIDTH         = 16;
   localparam int FREE_COUNT_WIDTH    = 5;
   localparam int STATUS_WIDTH        = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic write_cur;   // overwrite the selected entry
      logic write_prev;  // overwrite the size of the entry before it
      logic remove;      // close the gap at the selected entry
      logic insert;      // open a gap at the selected entry
      logic split;       // with insert: the entry after the gap takes the upper piece
   } cell_cmd_type;

endpackage

FILE: rtl/free_extent_range_allocator.sv
// Free extent allocator for a memory of memory_size addresses.
// Requests arrive as beats on the req_ channel: tuser carries the operation
// (allocate or free), tdata the start and length of the range. Each request
// gives exactly one beat on the rsp_ channel with a status and the number of
// free extents left. A beat on the csr_ channel sets memory_size and turns the
// table into one extent covering the whole memory, or an empty table for size 0.
// The table sits in a row of cells, one extent each. The search for the first
// matching extent ripples one cell per cycle through the row; then the decide
// step chooses the update, the apply step lets every cell shift or rewrite
// its entry at once, and the done step loads the response register, which
// raises rsp_tvalid.
// One request is in flight at a time; a new request is taken as soon as the
// response has moved into the output register, even while that beat still
// waits for rsp_tready.
// A stalled receiver holds the response beat; the block then finishes the
// request in hand and waits before loading the next response.
// Reset gives memory_size 4096 and one free extent starting at address 0.
module free_extent_range_allocator #(
   parameter int MAX_EXTENTS = fera_pkg::MAX_EXTENTS_DEFAULT,
   parameter int ADDR_WIDTH  = fera_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fera_pkg::FIELD_WIDTH-1:0]   csr_data,   // memory_size
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [2*fera_pkg::FIELD_WIDTH-1:0] req_tdata,  // range_start, range_length
   input  logic                               req_tuser,  // func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata   // status, free_extent_count, pad
);
   import fera_pkg::*;

   localparam int CountWidth   = $clog2(MAX_EXTENTS + 1);
   localparam int ScanWidth    = $clog2(MAX_EXTENTS);
   localparam logic [ScanWidth-1:0]  ScanLast  = ScanWidth'(MAX_EXTENTS - 1);
   localparam logic [ADDR_WIDTH-1:0] ResetSize = ADDR_WIDTH'(MEMORY_SIZE_RESET);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_APPLY  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [ScanWidth-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   func_ff;
   logic [ADDR_WIDTH-1:0]  start_ff, length_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff;
   logic [FREE_COUNT_WIDTH-1:0] rsp_count_ff;

   logic                   req_take, csr_take, rsp_free;
   logic                   init;
   logic [ADDR_WIDTH-1:0]  init_size;

   cell_cmd_type           cmd;
   status_type             status;
   logic [ADDR_WIDTH:0]    wr_base, up_base;
   logic [ADDR_WIDTH-1:0]  wr_size, up_size, prev_size;

   logic                   c_valid     [MAX_EXTENTS];
   logic [ADDR_WIDTH:0]    c_base      [MAX_EXTENTS];
   logic [ADDR_WIDTH-1:0]  c_size      [MAX_EXTENTS];
   logic                   c_at        [MAX_EXTENTS];
   logic                   c_first     [MAX_EXTENTS];
   logic                   c_open      [MAX_EXTENTS];
   logic                   c_cur_found [MAX_EXTENTS];
   logic [ADDR_WIDTH:0]    c_cur_base  [MAX_EXTENTS];
   logic [ADDR_WIDTH-1:0]  c_cur_size  [MAX_EXTENTS];
   logic                   c_prv_found [MAX_EXTENTS];
   logic [ADDR_WIDTH:0]    c_prv_base  [MAX_EXTENTS];
   logic [ADDR_WIDTH-1:0]  c_prv_size  [MAX_EXTENTS];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_take   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign init      = reset || csr_take;
   assign init_size = reset ? ResetSize : ADDR_WIDTH'(csr_data);

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == ScanLast) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (init) begin
         count_in = (init_size != '0) ? CountWidth'(1) : '0;
      end else if (state_ff == ST_APPLY) begin
         if (cmd.insert) begin
            count_in = count_ff + 1'b1;
         end else if (cmd.remove) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
      if (req_take) begin
         func_ff   <= req_tuser;
         start_ff  <= ADDR_WIDTH'(req_tdata[FIELD_WIDTH-1:0]);
         length_ff <= ADDR_WIDTH'(req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]);
      end
      // hold the response beat until the receiver takes it
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= FREE_COUNT_WIDTH'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_status_ff};

   fera_decide #(
      .MAX_EXTENTS (MAX_EXTENTS),
      .ADDR_WIDTH  (ADDR_WIDTH),
      .COUNT_WIDTH (CountWidth)
   ) u_decide (
      .clock      (clock),
      .reset      (reset),
      .enable     (state_ff == ST_DECIDE),
      .func       (func_ff),
      .start      (start_ff),
      .length     (length_ff),
      .count      (count_ff),
      .first_open (c_open[0]),
      .cur_found  (c_cur_found[0]),
      .cur_base   (c_cur_base[0]),
      .cur_size   (c_cur_size[0]),
      .prv_found  (c_prv_found[0]),
      .prv_base   (c_prv_base[0]),
      .prv_size   (c_prv_size[0]),
      .cmd        (cmd),
      .status     (status),
      .wr_base    (wr_base),
      .wr_size    (wr_size),
      .up_base    (up_base),
      .up_size    (up_size),
      .prev_size  (prev_size)
   );

   for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
      logic                  lo_valid, lo_at, lo_first;
      logic [ADDR_WIDTH:0]   lo_base;
      logic [ADDR_WIDTH-1:0] lo_size;
      logic                  hi_valid, hi_at, hi_open, hi_cur_found, hi_prv_found;
      logic [ADDR_WIDTH:0]   hi_base, hi_cur_base, hi_prv_base;
      logic [ADDR_WIDTH-1:0] hi_size, hi_cur_size, hi_prv_size;

      if (k == 0) begin : g_lo_edge
         assign lo_valid = 1'b0;
         assign lo_base  = '0;
         assign lo_size  = '0;
         assign lo_at    = 1'b0;
         assign lo_first = 1'b0;
      end else begin : g_lo
         assign lo_valid = c_valid[k-1];
         assign lo_base  = c_base[k-1];
         assign lo_size  = c_size[k-1];
         assign lo_at    = c_at[k-1];
         assign lo_first = c_first[k-1];
      end

      if (k == MAX_EXTENTS - 1) begin : g_hi_edge
         // past the end of the table counts as the insertion point
         assign hi_valid     = 1'b0;
         assign hi_base      = '0;
         assign hi_size      = '0;
         assign hi_at        = 1'b1;
         assign hi_open      = 1'b1;
         assign hi_cur_found = 1'b0;
         assign hi_cur_base  = '0;
         assign hi_cur_size  = '0;
         assign hi_prv_found = 1'b0;
         assign hi_prv_base  = '0;
         assign hi_prv_size  = '0;
      end else begin : g_hi
         assign hi_valid     = c_valid[k+1];
         assign hi_base      = c_base[k+1];
         assign hi_size      = c_size[k+1];
         assign hi_at        = c_at[k+1];
         assign hi_open      = c_open[k+1];
         assign hi_cur_found = c_cur_found[k+1];
         assign hi_cur_base  = c_cur_base[k+1];
         assign hi_cur_size  = c_cur_size[k+1];
         assign hi_prv_found = c_prv_found[k+1];
         assign hi_prv_base  = c_prv_base[k+1];
         assign hi_prv_size  = c_prv_size[k+1];
      end

      fera_cell #(
         .ADDR_WIDTH (ADDR_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .init         (init),
         .init_valid   ((k == 0) && (init_size != '0)),
         .init_size    (init_size),
         .scan         (state_ff == ST_SCAN),
         .strict       (func_ff == FUNC_FREE),
         .start        (start_ff),
         .apply        (state_ff == ST_APPLY),
         .cmd          (cmd),
         .wr_base      (wr_base),
         .wr_size      (wr_size),
         .up_base      (up_base),
         .up_size      (up_size),
         .prev_size    (prev_size),
         .lo_valid     (lo_valid),
         .lo_base      (lo_base),
         .lo_size      (lo_size),
         .lo_at        (lo_at),
         .lo_first     (lo_first),
         .hi_valid     (hi_valid),
         .hi_base      (hi_base),
         .hi_size      (hi_size),
         .hi_at        (hi_at),
         .hi_open      (hi_open),
         .hi_cur_found (hi_cur_found),
         .hi_cur_base  (hi_cur_base),
         .hi_cur_size  (hi_cur_size),
         .hi_prv_found (hi_prv_found),
         .hi_prv_base  (hi_prv_base),
         .hi_prv_size  (hi_prv_size),
         .valid        (c_valid[k]),
         .base         (c_base[k]),
         .size         (c_size[k]),
         .at           (c_at[k]),
         .first        (c_first[k]),
         .open         (c_open[k]),
         .cur_found    (c_cur_found[k]),
         .cur_base     (c_cur_base[k]),
         .cur_size     (c_cur_size[k]),
         .prv_found    (c_prv_found[k]),
         .prv_base     (c_prv_base[k]),
         .prv_size     (c_prv_size[k])
      );
   end

endmodule

FILE: rtl/fera_cell.sv
module fera_cell #(
   parameter int ADDR_WIDTH = fera_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    init,
   input  logic                    init_valid,
   input  logic [ADDR_WIDTH-1:0]   init_size,
   input  logic                    scan,
   input  logic                    strict,
   input  logic [ADDR_WIDTH-1:0]   start,
   input  logic                    apply,
   input  fera_pkg::cell_cmd_type  cmd,
   input  logic [ADDR_WIDTH:0]     wr_base,
   input  logic [ADDR_WIDTH-1:0]   wr_size,
   input  logic [ADDR_WIDTH:0]     up_base,
   input  logic [ADDR_WIDTH-1:0]   up_size,
   input  logic [ADDR_WIDTH-1:0]   prev_size,
   // neighbour below
   input  logic                    lo_valid,
   input  logic [ADDR_WIDTH:0]     lo_base,
   input  logic [ADDR_WIDTH-1:0]   lo_size,
   input  logic                    lo_at,
   input  logic                    lo_first,
   // neighbour above
   input  logic                    hi_valid,
   input  logic [ADDR_WIDTH:0]     hi_base,
   input  logic [ADDR_WIDTH-1:0]   hi_size,
   input  logic                    hi_at,
   input  logic                    hi_open,
   input  logic                    hi_cur_found,
   input  logic [ADDR_WIDTH:0]     hi_cur_base,
   input  logic [ADDR_WIDTH-1:0]   hi_cur_size,
   input  logic                    hi_prv_found,
   input  logic [ADDR_WIDTH:0]     hi_prv_base,
   input  logic [ADDR_WIDTH-1:0]   hi_prv_size,
   // own state
   output logic                    valid,
   output logic [ADDR_WIDTH:0]     base,
   output logic [ADDR_WIDTH-1:0]   size,
   output logic                    at,
   output logic                    first,
   output logic                    open,
   output logic                    cur_found,
   output logic [ADDR_WIDTH:0]     cur_base,
   output logic [ADDR_WIDTH-1:0]   cur_size,
   output logic                    prv_found,
   output logic [ADDR_WIDTH:0]     prv_base,
   output logic [ADDR_WIDTH-1:0]   prv_size
);
   import fera_pkg::*;

   logic                  valid_ff, valid_in;
   logic [ADDR_WIDTH:0]   base_ff, base_in;
   logic [ADDR_WIDTH-1:0] size_ff, size_in;
   logic                  at_ff;
   logic                  cur_found_ff;
   logic [ADDR_WIDTH:0]   cur_base_ff;
   logic [ADDR_WIDTH-1:0] cur_size_ff;
   logic                  prv_found_ff;
   logic [ADDR_WIDTH:0]   prv_base_ff;
   logic [ADDR_WIDTH-1:0] prv_size_ff;

   logic [ADDR_WIDTH+1:0] end_addr;
   logic                  hit;
   logic                  is_first;
   logic                  is_prev;
   logic                  above;

   assign end_addr = (ADDR_WIDTH+2)'(base_ff) + (ADDR_WIDTH+2)'(size_ff);
   assign hit      = valid_ff && (strict ? (end_addr > (ADDR_WIDTH+2)'(start))
                                         : (end_addr >= (ADDR_WIDTH+2)'(start)));
   assign open     = hit || !valid_ff;

   assign is_first = at_ff && !lo_at;
   assign is_prev  = hi_at && !at_ff;
   assign above    = at_ff && !is_first;

   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      size_in  = size_ff;
      if (reset || init) begin
         valid_in = init_valid;
         base_in  = '0;
         size_in  = init_size;
      end else if (apply) begin
         if (cmd.write_prev && is_prev) begin
            size_in = prev_size;
         end
         if (cmd.remove && at_ff) begin
            valid_in = hi_valid;
            base_in  = hi_base;
            size_in  = hi_size;
         end else if (cmd.insert && is_first) begin
            valid_in = 1'b1;
            base_in  = wr_base;
            size_in  = wr_size;
         end else if (cmd.insert && cmd.split && lo_first) begin
            valid_in = 1'b1;
            base_in  = up_base;
            size_in  = up_size;
         end else if (cmd.insert && above) begin
            valid_in = lo_valid;
            base_in  = lo_base;
            size_in  = lo_size;
         end else if (cmd.write_cur && is_first) begin
            base_in = wr_base;
            size_in = wr_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      base_ff  <= base_in;
      size_ff  <= size_in;
      if (reset) begin
         at_ff <= 1'b0;
      end else if (scan) begin
         at_ff <= open || lo_at;
      end
      // first hit travels down the row, one cell a cycle
      if (scan) begin
         if (hit) begin
            cur_found_ff <= 1'b1;
            cur_base_ff  <= base_ff;
            cur_size_ff  <= size_ff;
         end else begin
            cur_found_ff <= hi_cur_found;
            cur_base_ff  <= hi_cur_base;
            cur_size_ff  <= hi_cur_size;
         end
         if (hi_open && !open) begin
            prv_found_ff <= 1'b1;
            prv_base_ff  <= base_ff;
            prv_size_ff  <= size_ff;
         end else begin
            prv_found_ff <= hi_prv_found;
            prv_base_ff  <= hi_prv_base;
            prv_size_ff  <= hi_prv_size;
         end
      end
   end

   assign valid     = valid_ff;
   assign base      = base_ff;
   assign size      = size_ff;
   assign at        = at_ff;
   assign first     = is_first;
   assign cur_found = cur_found_ff;
   assign cur_base  = cur_base_ff;
   assign cur_size  = cur_size_ff;
   assign prv_found = prv_found_ff;
   assign prv_base  = prv_base_ff;
   assign prv_size  = prv_size_ff;

endmodule

FILE: rtl/fera_decide.sv
module fera_decide #(
   parameter int MAX_EXTENTS = fera_pkg::MAX_EXTENTS_DEFAULT,
   parameter int ADDR_WIDTH  = fera_pkg::ADDR_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(MAX_EXTENTS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    func,
   input  logic [ADDR_WIDTH-1:0]   start,
   input  logic [ADDR_WIDTH-1:0]   length,
   input  logic [COUNT_WIDTH-1:0]  count,
   input  logic                    first_open,
   input  logic                    cur_found,
   input  logic [ADDR_WIDTH:0]     cur_base,
   input  logic [ADDR_WIDTH-1:0]   cur_size,
   input  logic                    prv_found,
   input  logic [ADDR_WIDTH:0]     prv_base,
   input  logic [ADDR_WIDTH-1:0]   prv_size,
   output fera_pkg::cell_cmd_type  cmd,
   output fera_pkg::status_type    status,
   output logic [ADDR_WIDTH:0]     wr_base,
   output logic [ADDR_WIDTH-1:0]   wr_size,
   output logic [ADDR_WIDTH:0]     up_base,
   output logic [ADDR_WIDTH-1:0]   up_size,
   output logic [ADDR_WIDTH-1:0]   prev_size
);
   import fera_pkg::*;

   localparam int EndWidth = ADDR_WIDTH + 2;

   cell_cmd_type          cmd_ff, cmd_in;
   status_type            status_ff, status_in;
   logic [ADDR_WIDTH:0]   wr_base_ff, wr_base_in;
   logic [ADDR_WIDTH-1:0] wr_size_ff, wr_size_in;
   logic [ADDR_WIDTH:0]   up_base_ff, up_base_in;
   logic [ADDR_WIDTH-1:0] up_size_ff, up_size_in;
   logic [ADDR_WIDTH-1:0] prev_size_ff, prev_size_in;

   logic [ADDR_WIDTH:0]   stop;
   logic [EndWidth-1:0]   cur_end, prv_end, left_w, right_w;
   logic [ADDR_WIDTH-1:0] left, right;
   logic                  in_range, full, join_next, join_prev, prev_ok;
   logic [ADDR_WIDTH:0]   sum_prev, sum_cur;
   logic [EndWidth-1:0]   sum_both;
   logic [ADDR_WIDTH-1:0] sat_prev, sat_cur, sat_both;

   assign stop     = (ADDR_WIDTH+1)'(start) + (ADDR_WIDTH+1)'(length);
   assign cur_end  = EndWidth'(cur_base) + EndWidth'(cur_size);
   assign prv_end  = EndWidth'(prv_base) + EndWidth'(prv_size);
   assign left_w   = EndWidth'(start) - EndWidth'(cur_base);
   assign right_w  = cur_end - EndWidth'(stop);
   assign left     = left_w[ADDR_WIDTH-1:0];
   assign right    = right_w[ADDR_WIDTH-1:0];
   assign in_range = cur_found && (EndWidth'(start) >= EndWidth'(cur_base))
                     && (EndWidth'(stop) <= cur_end);
   assign full     = count >= COUNT_WIDTH'(MAX_EXTENTS);

   // no entry before the insertion point when the first cell already qualifies
   assign prev_ok   = prv_found && !first_open;
   assign join_next = cur_found && (stop == cur_base);
   assign join_prev = prev_ok && (prv_end == EndWidth'(start));

   assign sum_prev = (ADDR_WIDTH+1)'(prv_size) + (ADDR_WIDTH+1)'(length);
   assign sum_cur  = (ADDR_WIDTH+1)'(cur_size) + (ADDR_WIDTH+1)'(length);
   assign sum_both = EndWidth'(sum_prev) + EndWidth'(cur_size);
   assign sat_prev = sum_prev[ADDR_WIDTH] ? {ADDR_WIDTH{1'b1}} : sum_prev[ADDR_WIDTH-1:0];
   assign sat_cur  = sum_cur[ADDR_WIDTH] ? {ADDR_WIDTH{1'b1}} : sum_cur[ADDR_WIDTH-1:0];
   assign sat_both = (sum_both[EndWidth-1:ADDR_WIDTH] != '0) ? {ADDR_WIDTH{1'b1}}
                                                              : sum_both[ADDR_WIDTH-1:0];

   always_comb begin
      cmd_in       = '0;
      status_in    = STATUS_DONE;
      wr_base_in   = cur_base;
      wr_size_in   = cur_size;
      up_base_in   = stop;
      up_size_in   = right;
      prev_size_in = sat_prev;
      if (length != '0) begin
         if (func == FUNC_ALLOC) begin
            if (!in_range) begin
               status_in = STATUS_RANGE;
            end else if (left != '0 && right != '0) begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd_in.insert = 1'b1;
                  cmd_in.split  = 1'b1;
                  wr_size_in    = left;
               end
            end else if (left != '0) begin
               cmd_in.write_cur = 1'b1;
               wr_size_in       = left;
            end else if (right != '0) begin
               cmd_in.write_cur = 1'b1;
               wr_base_in       = stop;
               wr_size_in       = right;
            end else begin
               cmd_in.remove = 1'b1;
            end
         end else begin
            if (join_next && join_prev) begin
               cmd_in.write_prev = 1'b1;
               cmd_in.remove     = 1'b1;
               prev_size_in      = sat_both;
            end else if (join_prev) begin
               cmd_in.write_prev = 1'b1;
            end else if (join_next) begin
               cmd_in.write_cur = 1'b1;
               wr_base_in       = (ADDR_WIDTH+1)'(start);
               wr_size_in       = sat_cur;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               cmd_in.insert = 1'b1;
               wr_base_in    = (ADDR_WIDTH+1)'(start);
               wr_size_in    = length;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff    <= '0;
         status_ff <= STATUS_DONE;
      end else if (enable) begin
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
      end
      if (enable) begin
         wr_base_ff   <= wr_base_in;
         wr_size_ff   <= wr_size_in;
         up_base_ff   <= up_base_in;
         up_size_ff   <= up_size_in;
         prev_size_ff <= prev_size_in;
      end
   end

   assign cmd       = cmd_ff;
   assign status    = status_ff;
   assign wr_base   = wr_base_ff;
   assign wr_size   = wr_size_ff;
   assign up_base   = up_base_ff;
   assign up_size   = up_size_ff;
   assign prev_size = prev_size_ff;

endmodule
